FILE: rtl/core/wti_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wti_pkg
// Shared codes and constants of the waveform table interpolator.
// ----------------------------------------------------------------------------
package wti_pkg;

	// Request command codes.
	localparam logic [2:0] CMD_WRITE_TIME   = 3'd0;
	localparam logic [2:0] CMD_WRITE_SAMPLE = 3'd1;
	localparam logic [2:0] CMD_EVALUATE     = 3'd2;
	localparam logic [2:0] CMD_READ_LAST    = 3'd3;
	localparam logic [2:0] CMD_ERROR_ELEM   = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_INTERP   = 2'd0;
	localparam logic [1:0] KIND_LAST_ROW = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_POINTS_IN_USE = 1'b0;
	localparam logic CFG_VECTOR_LENGTH = 1'b1;

	// Fixed point format and divider sizes.
	localparam int FRAC_BITS = 16;
	localparam int DIFF_W    = 33;
	localparam int QUOT_W    = DIFF_W + FRAC_BITS;

	localparam logic [62:0] ERR_MAX = {63{1'b1}};

endpackage
`default_nettype wire

FILE: rtl/core/wti_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wti_div
// Bit-serial signed divider that forms the Q16.16 interpolation factor
// (num * 65536) / den, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module wti_div
	import wti_pkg::*;
(
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire  signed [DIFF_W-1:0]   num,
	input  wire  signed [DIFF_W-1:0]   den,
	output logic                       done,
	output logic signed [31:0]         factor
);

	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic              neg_q;
	logic [5:0]        cnt_q;
	logic [QUOT_W-1:0] nq_q;
	logic [DIFF_W-1:0] rem_q;
	logic [DIFF_W-1:0] den_q;
	logic signed [31:0] factor_q;

	logic [DIFF_W-1:0] num_mag;
	logic [DIFF_W-1:0] den_mag;
	logic [DIFF_W:0]   trial;
	logic              qbit;

	assign num_mag = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
	assign den_mag = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
	assign trial   = {rem_q, nq_q[QUOT_W-1]};
	assign qbit    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			factor_q <= '0;
			nq_q     <= {num_mag, {FRAC_BITS{1'b0}}};
			rem_q    <= '0;
			den_q    <= den_mag;
			neg_q    <= num[DIFF_W-1] ^ den[DIFF_W-1];
			cnt_q    <= 6'(QUOT_W);
		end else if (busy_q) begin
			rem_q <= qbit ? DIFF_W'(trial - {1'b0, den_q}) : DIFF_W'(trial);
			nq_q  <= {nq_q[QUOT_W-2:0], qbit};
			cnt_q <= cnt_q - 6'd1;
		end else if (fin_q) begin
			// Saturate the magnitude, then apply the sign.
			if (neg_q) begin
				if (nq_q > QUOT_W'(33'h0_8000_0000)) begin
					factor_q <= 32'sh8000_0000;
				end else begin
					factor_q <= 32'(-nq_q);
				end
			end else begin
				if (nq_q > QUOT_W'(33'h0_7FFF_FFFF)) begin
					factor_q <= 32'sh7FFF_FFFF;
				end else begin
					factor_q <= 32'(nq_q);
				end
			end
		end
	end

	assign done   = done_q;
	assign factor = factor_q;

endmodule
`default_nettype wire

FILE: rtl/core/waveform_table_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_table_interpolator
// Piecewise linear waveform table with sample read-back and a saturating
// squared error accumulator; times and samples are signed Q16.16, the sum unsigned Q47.16.
// ----------------------------------------------------------------------------
// An evaluation is accepted, searches the time table for its interval, starts
// and runs the divider (which skips the division when the interval has zero
// width) and then produces one result per element. A last-row read produces one
// result per element, an error element produces a result only with the final
// flag; a stalled result holds the sequencer until it is taken.
// Reset clears control, accumulator and registers (64 points, 16 elements), not tables.
// ----------------------------------------------------------------------------
module waveform_table_interpolator
	import wti_pkg::*;
#(
	parameter int MAX_POINTS   = 64,
	parameter int MAX_ELEMENTS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	// Configuration write port.
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire  [6:0]         cfg_data,
	// Request channel.
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [2:0]         cmd,
	input  wire  [5:0]         point,
	input  wire  [3:0]         element,
	input  wire  signed [31:0] sample_in,
	input  wire  signed [31:0] time_in,
	input  wire                final_element,
	// Result channel.
	output logic               out_valid,
	input  wire                out_stall,
	output logic [1:0]         kind,
	output logic signed [31:0] sample_out,
	output logic [62:0]        error_sum,
	output logic               last_of_run
);

	// Index widths that follow from the table sizes.
	localparam int PW = $clog2(MAX_POINTS);
	localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int AW = $clog2(MAX_POINTS * MAX_ELEMENTS);
	localparam int DEPTH = MAX_POINTS * MAX_ELEMENTS;

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_TWAIT = 4'd1;
	localparam logic [3:0] S_TCMP  = 4'd2;
	localparam logic [3:0] S_DSTRT = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_ERD   = 4'd5;
	localparam logic [3:0] S_EMUL  = 4'd6;
	localparam logic [3:0] S_EOUT  = 4'd7;
	localparam logic [3:0] S_XRD   = 4'd8;
	localparam logic [3:0] S_XMUL  = 4'd9;
	localparam logic [3:0] S_XACC  = 4'd10;
	localparam logic [3:0] S_XOUT  = 4'd11;

	// The two tables live in synchronous memories with registered reads.
	logic signed [31:0] time_mem [MAX_POINTS];
	logic signed [31:0] sample_mem [DEPTH];

	logic [3:0]  state_q;
	logic [6:0]  points_in_use_q;
	logic [4:0]  vector_length_q;
	logic [62:0] acc_q;

	logic [PW-1:0]       idx_q;
	logic [EW-1:0]       e_q;
	logic [AW-1:0]       base_a_q;
	logic [AW-1:0]       base_b_q;
	logic [1:0]          kind_q;
	logic                final_q;
	logic                in_range_q;
	logic signed [31:0]  t_q;
	logic signed [31:0]  sample_q;
	logic signed [31:0]  tprev_q;
	logic signed [31:0]  thi_q;
	logic signed [31:0]  f_q;
	logic signed [31:0]  t_rd_q;
	logic signed [31:0]  a_rd_q;
	logic signed [31:0]  b_rd_q;
	logic signed [31:0]  a_s2;
	logic signed [64:0]  prod_s2;
	logic [65:0]         sq_s2;

	logic               out_valid_q;
	logic [1:0]         kind_q_out;
	logic signed [31:0] sample_out_q;
	logic [62:0]        error_sum_q;
	logic               last_q;

	logic                      accept;
	logic                      out_free;
	logic [PW-1:0]             n_m1;
	logic [EW-1:0]             len_m1;
	logic [AW-1:0]             base_last;
	logic [AW-1:0]             rd_addr_a;
	logic [AW-1:0]             rd_addr_b;
	logic                      div_done;
	logic signed [31:0]        div_factor;
	logic signed [DIFF_W-1:0]  dt;
	logic signed [DIFF_W-1:0]  num;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [DIFF_W-1:0]  err_d;
	logic [DIFF_W-1:0]         err_mag;
	logic signed [49:0]        interp;
	logic signed [31:0]        interp_sat;
	logic [63:0]               acc_sum;
	logic [31:0]               n_clamped;
	logic [31:0]               len_clamped;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Registers are clamped to their legal ranges where they are used.
	always_comb begin
		if (points_in_use_q < 7'd2) begin
			n_clamped = 32'd2;
		end else if (32'(points_in_use_q) > 32'(MAX_POINTS)) begin
			n_clamped = 32'(MAX_POINTS);
		end else begin
			n_clamped = 32'(points_in_use_q);
		end
		if (vector_length_q == 5'd0) begin
			len_clamped = 32'd1;
		end else if (32'(vector_length_q) > 32'(MAX_ELEMENTS)) begin
			len_clamped = 32'(MAX_ELEMENTS);
		end else begin
			len_clamped = 32'(vector_length_q);
		end
	end

	assign n_m1      = PW'(n_clamped - 32'd1);
	assign len_m1    = EW'(len_clamped - 32'd1);
	assign base_last = AW'(32'(n_m1) * 32'(MAX_ELEMENTS));
	assign rd_addr_a = base_a_q + AW'(e_q);
	assign rd_addr_b = base_b_q + AW'(e_q);

	// Interval width and offset of t within it feed the divider.
	assign dt = DIFF_W'(thi_q) - DIFF_W'(tprev_q);
	assign num = DIFF_W'(t_q) - DIFF_W'(tprev_q);

	wti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DSTRT),
		.num    (num),
		.den    (dt),
		.done   (div_done),
		.factor (div_factor)
	);

	// Element arithmetic: a + floor(f * (b - a) / 65536), saturated.
	assign diff   = DIFF_W'(b_rd_q) - DIFF_W'(a_rd_q);
	assign interp = 50'(a_s2) + 50'(prod_s2 >>> FRAC_BITS);
	always_comb begin
		if (interp > 50'sh0_0000_7FFF_FFFF) begin
			interp_sat = 32'sh7FFF_FFFF;
		end else if (interp < -50'sh0_0000_8000_0000) begin
			interp_sat = 32'sh8000_0000;
		end else begin
			interp_sat = 32'(interp);
		end
	end

	// Squared error of the last row against the request sample.
	assign err_d   = DIFF_W'(a_rd_q) - DIFF_W'(sample_q);
	assign err_mag = err_d[DIFF_W-1] ? DIFF_W'(-err_d) : DIFF_W'(err_d);
	assign acc_sum = {1'b0, acc_q} + 64'(sq_s2 >> FRAC_BITS);

	// Memory ports: one write port each, registered reads.
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_WRITE_TIME && 32'(point) < 32'(MAX_POINTS)) begin
			time_mem[PW'(point)] <= time_in;
		end
		t_rd_q <= time_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_WRITE_SAMPLE && 32'(point) < 32'(MAX_POINTS)
				&& 32'(element) < 32'(MAX_ELEMENTS)) begin
			sample_mem[AW'(32'(point) * 32'(MAX_ELEMENTS) + 32'(element))] <= sample_in;
		end
		a_rd_q <= sample_mem[rd_addr_a];
		b_rd_q <= sample_mem[rd_addr_b];
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			points_in_use_q <= 7'd64;
			vector_length_q <= 5'd16;
			acc_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_POINTS_IN_USE: points_in_use_q <= cfg_data;
					CFG_VECTOR_LENGTH: vector_length_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_EVALUATE:   state_q <= S_TWAIT;
							CMD_READ_LAST:  state_q <= S_ERD;
							CMD_ERROR_ELEM: state_q <= S_XRD;
							default:        state_q <= S_IDLE;
						endcase
					end
				end
				S_TWAIT: state_q <= S_TCMP;
				S_TCMP: begin
					// Stop at the first later time above t, or at the last interval.
					if (idx_q != '0 && (t_rd_q > t_q || idx_q == n_m1)) begin
						state_q <= S_DSTRT;
					end else begin
						state_q <= S_TWAIT;
					end
				end
				S_DSTRT: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_ERD;
					end
				end
				S_ERD:  state_q <= S_EMUL;
				S_EMUL: state_q <= S_EOUT;
				S_EOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= (e_q == len_m1) ? S_IDLE : S_ERD;
					end
				end
				S_XRD:  state_q <= S_XMUL;
				S_XMUL: state_q <= S_XACC;
				S_XACC: begin
					if (in_range_q) begin
						acc_q <= (acc_sum > {1'b0, ERR_MAX}) ? ERR_MAX : acc_sum[62:0];
					end
					state_q <= final_q ? S_XOUT : S_IDLE;
				end
				S_XOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						acc_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q        <= time_in;
				sample_q   <= sample_in;
				final_q    <= final_element;
				in_range_q <= (32'(element) <= 32'(len_m1));
				idx_q      <= '0;
				base_a_q   <= base_last;
				base_b_q   <= base_last;
				e_q        <= (cmd == CMD_ERROR_ELEM) ? EW'(element) : '0;
				kind_q     <= (cmd == CMD_EVALUATE) ? KIND_INTERP : KIND_LAST_ROW;
			end
			S_TCMP: begin
				if (idx_q != '0 && (t_rd_q > t_q || idx_q == n_m1)) begin
					thi_q    <= t_rd_q;
					base_a_q <= AW'(32'(idx_q - PW'(1)) * 32'(MAX_ELEMENTS));
					base_b_q <= AW'(32'(idx_q) * 32'(MAX_ELEMENTS));
				end else begin
					tprev_q <= t_rd_q;
					idx_q   <= idx_q + PW'(1);
				end
			end
			S_DIV: begin
				f_q <= div_factor;
			end
			S_EMUL: begin
				a_s2 <= a_rd_q;
				// A row read-back passes the sample through unchanged.
				prod_s2 <= (kind_q == KIND_INTERP) ? 65'(f_q * diff) : '0;
			end
			S_EOUT: begin
				if (out_free) begin
					kind_q_out   <= kind_q;
					sample_out_q <= interp_sat;
					error_sum_q  <= '0;
					last_q       <= (e_q == len_m1);
					e_q          <= e_q + EW'(1);
				end
			end
			S_XMUL: begin
				sq_s2 <= 66'(err_mag) * 66'(err_mag);
			end
			S_XOUT: begin
				if (out_free) begin
					kind_q_out   <= KIND_ERROR;
					sample_out_q <= '0;
					error_sum_q  <= acc_q;
					last_q       <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q_out;
	assign sample_out  = sample_out_q;
	assign error_sum   = error_sum_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the waveform table interpolator. The rows that
// the directed requests reach are preloaded, a short table of directed
// requests covers extremes and corner cases, then random requests run under
// several register settings, each phase first writing the entries it can
// reach. Every result is compared against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb;
	import wti_pkg::*;

	localparam int NPTS   = 64;
	localparam int NELEM  = 16;
	localparam int LIMIT  = 1000000;
	localparam int SETTLE = 300;
	localparam int NPHASE = 4;
	localparam int NRAND  = 20;
	localparam logic [63:0] ACC_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [5:0]         point;
		logic [3:0]         element;
		logic signed [31:0] sample;
		logic signed [31:0] tm;
		logic               fin;
	} request_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] sample;
		logic [62:0]        esum;
		logic               last;
	} result_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		result_t  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [6:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = '0;
	logic [5:0] point = '0;
	logic [3:0] element = '0;
	logic signed [31:0] sample_in = '0;
	logic signed [31:0] time_in = '0;
	logic final_element = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic signed [31:0] sample_out;
	logic [62:0] error_sum;
	logic last_of_run;

	waveform_table_interpolator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .point(point), .element(element),
		.sample_in(sample_in), .time_in(time_in), .final_element(final_element),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .sample_out(sample_out), .error_sum(error_sum),
		.last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	// Shadow copy of the block's state, kept by the predictor, with a mark
	// for every sample entry that has been written.
	logic signed [31:0] time_copy [NPTS];
	logic signed [31:0] sample_copy [NPTS*NELEM];
	bit sample_known [NPTS*NELEM];
	logic [63:0] err_acc;
	logic [6:0] points_reg;
	logic [4:0] length_reg;

	result_t pending_results [$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;

	task automatic report(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	function automatic int used_points();
		int n;
		n = points_reg;
		if (n < 2) n = 2;
		if (n > NPTS) n = NPTS;
		return n;
	endfunction

	function automatic int used_length();
		int n;
		n = length_reg;
		if (n < 1) n = 1;
		if (n > NELEM) n = NELEM;
		return n;
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Applies one accepted request to the shadow state and queues the
	// results it should produce, unless a typed expectation replaces them.
	task automatic predict_request(input request_t r, input bit queue_it);
		int n, len, idx, lo, i;
		longint dt, num, f, a, b, d;
		logic [63:0] m, term;
		result_t res;
		n = used_points();
		len = used_length();
		case (r.cmd)
			CMD_WRITE_TIME: time_copy[r.point] = r.tm;
			CMD_WRITE_SAMPLE: begin
				sample_copy[r.point*NELEM + r.element] = r.sample;
				sample_known[r.point*NELEM + r.element] = 1'b1;
			end
			CMD_EVALUATE: begin
				idx = 1;
				while (idx < n && !(time_copy[idx] > r.tm)) idx++;
				if (idx == n) idx--;
				lo = idx - 1;
				dt = longint'(time_copy[lo+1]) - longint'(time_copy[lo]);
				num = longint'(r.tm) - longint'(time_copy[lo]);
				// Equal neighboring times give a zero factor.
				f = (dt == 0) ? 0 : (num * 65536) / dt;
				if (f > 64'sd2147483647) f = 64'sd2147483647;
				if (f < -64'sd2147483648) f = -64'sd2147483648;
				for (i = 0; i < len; i++) begin
					a = sample_copy[lo*NELEM + i];
					b = sample_copy[(lo+1)*NELEM + i];
					res = '{KIND_INTERP, clip32(a + ((f * (b - a)) >>> 16)), '0,
						i == len - 1};
					if (queue_it) pending_results.push_back(res);
				end
			end
			CMD_READ_LAST: begin
				for (i = 0; i < len; i++) begin
					res = '{KIND_LAST_ROW, sample_copy[(n-1)*NELEM + i], '0, i == len - 1};
					if (queue_it) pending_results.push_back(res);
				end
			end
			CMD_ERROR_ELEM: begin
				if (r.element < len) begin
					d = longint'(sample_copy[(n-1)*NELEM + r.element]) - longint'(r.sample);
					m = (d < 0) ? -d : d;
					term = (m * m) >> 16;
					if (term > ACC_MAX - err_acc) err_acc = ACC_MAX;
					else err_acc = err_acc + term;
				end
				if (r.fin) begin
					res = '{KIND_ERROR, '0, err_acc[62:0], 1'b1};
					if (queue_it) pending_results.push_back(res);
					err_acc = '0;
				end
			end
			default: ;
		endcase
	endtask

	// Offers one request and returns at the falling edge after acceptance.
	// The sender works in bursts; between bursts valid drops for a while.
	task automatic send_request(input request_t r, input bit typed, input result_t want);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		cmd <= r.cmd;
		point <= r.point;
		element <= r.element;
		sample_in <= r.sample;
		time_in <= r.tm;
		final_element <= r.fin;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_request(r, !typed);
		if (typed) pending_results.push_back(want);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_plain(input request_t r);
		send_request(r, 1'b0, '0);
	endtask

	// Waits until no result is outstanding, then lets the block settle,
	// since error elements without a final flag produce no result.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POINTS_IN_USE) points_reg = data;
		else length_reg = data[4:0];
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
	endfunction

	// Writes every sample entry that the current register setting can reach
	// and that has not been written yet.
	task automatic fill_reachable();
		request_t r;
		int p, e;
		for (p = 0; p < used_points(); p++)
			for (e = 0; e < used_length(); e++)
				if (!sample_known[p*NELEM + e]) begin
					r = '{CMD_WRITE_SAMPLE, p[5:0], e[3:0], rand_word(), '0, 1'b0};
					send_plain(r);
				end
	endtask

	// Most evaluation times fall near the table, some land far outside it.
	function automatic logic signed [31:0] pick_time();
		longint lo_t, hi_t;
		lo_t = time_copy[0];
		hi_t = time_copy[used_points() - 1];
		if (hi_t < lo_t) hi_t = lo_t;
		if ($urandom_range(0, 9) < 2) return rand_word();
		return clip32(lo_t - 65536 + longint'($urandom_range(0, 32'hffffffff)) %
			(hi_t - lo_t + 131073));
	endfunction

	// Rewrites the points in use in ascending order with some repeated times.
	task automatic load_sorted_times();
		request_t r;
		longint t;
		int p;
		t = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
		for (p = 0; p < used_points(); p++) begin
			r = '{CMD_WRITE_TIME, p[5:0], 4'd0, '0, clip32(t), 1'b0};
			send_plain(r);
			t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1 << 18);
		end
	endtask

	function automatic request_t rand_request();
		request_t r;
		int w;
		r.point = $urandom_range(0, 63);
		r.element = $urandom_range(0, 15);
		r.sample = rand_word();
		r.tm = rand_word();
		r.fin = ($urandom_range(0, 3) == 0);
		w = $urandom_range(0, 99);
		if (w < 10) r.cmd = CMD_WRITE_TIME;
		else if (w < 30) r.cmd = CMD_WRITE_SAMPLE;
		else if (w < 55) r.cmd = CMD_EVALUATE;
		else if (w < 65) r.cmd = CMD_READ_LAST;
		else if (w < 95) r.cmd = CMD_ERROR_ELEM;
		else r.cmd = 3'($urandom_range(CMD_UNUSED_5, CMD_UNUSED_7));
		if (r.cmd == CMD_EVALUATE) r.tm = pick_time();
		// Half of the error vectors compare against values near the last row.
		if (r.cmd == CMD_ERROR_ELEM && $urandom_range(0, 1))
			r.sample = clip32(longint'(sample_copy[(used_points()-1)*NELEM + r.element])
				+ $signed($urandom_range(0, 1 << 16)) - (1 << 15));
		return r;
	endfunction

	// Directed requests. The preload writes time p*65536 and sample
	// (p*16+e)*4096, so element 1 of the last row holds 4132864.
	localparam int NDIR = 20;
	localparam dir_row_t DIR_ROWS [NDIR] = '{
		'{'{CMD_UNUSED_5, 6'd0, 4'd0, 32'sd0, 32'sd0, 1'b1}, 1'b0, '0},
		'{'{CMD_UNUSED_7, 6'd63, 4'd15, 32'sh7fffffff, 32'sh7fffffff, 1'b1}, 1'b0, '0},
		'{'{CMD_ERROR_ELEM, 6'd0, 4'd1, 32'sd4132864, 32'sd0, 1'b1}, 1'b1,
			'{KIND_ERROR, 32'sd0, 63'd0, 1'b1}},
		'{'{CMD_EVALUATE, 6'd0, 4'd0, 32'sd0, 32'sh80000000, 1'b0}, 1'b0, '0},
		'{'{CMD_EVALUATE, 6'd0, 4'd0, 32'sd0, 32'sh7fffffff, 1'b0}, 1'b0, '0},
		'{'{CMD_EVALUATE, 6'd0, 4'd0, 32'sd0, 32'sd98304, 1'b0}, 1'b0, '0},
		'{'{CMD_WRITE_SAMPLE, 6'd63, 4'd0, 32'sh7fffffff, 32'sd0, 1'b0}, 1'b0, '0},
		'{'{CMD_WRITE_SAMPLE, 6'd62, 4'd0, 32'sh80000000, 32'sd0, 1'b0}, 1'b0, '0},
		'{'{CMD_WRITE_SAMPLE, 6'd63, 4'd15, 32'sh80000000, 32'sd0, 1'b0}, 1'b0, '0},
		'{'{CMD_WRITE_SAMPLE, 6'd62, 4'd15, 32'sh7fffffff, 32'sd0, 1'b0}, 1'b0, '0},
		'{'{CMD_EVALUATE, 6'd0, 4'd0, 32'sd0, 32'sh7fffffff, 1'b0}, 1'b0, '0},
		'{'{CMD_READ_LAST, 6'd0, 4'd0, 32'sd0, 32'sd0, 1'b0}, 1'b0, '0},
		'{'{CMD_ERROR_ELEM, 6'd0, 4'd0, 32'sh80000000, 32'sd0, 1'b0}, 1'b0, '0},
		'{'{CMD_ERROR_ELEM, 6'd0, 4'd15, 32'sh7fffffff, 32'sd0, 1'b1}, 1'b0, '0},
		// Equal times at the end of the table: the factor is zero.
		'{'{CMD_WRITE_TIME, 6'd63, 4'd0, 32'sd0, 32'sh7fffffff, 1'b0}, 1'b0, '0},
		'{'{CMD_WRITE_TIME, 6'd62, 4'd0, 32'sd0, 32'sh7fffffff, 1'b0}, 1'b0, '0},
		'{'{CMD_EVALUATE, 6'd0, 4'd0, 32'sd0, 32'sh7fffffff, 1'b0}, 1'b0, '0},
		// Unsorted times: the search still stops at the first larger time.
		'{'{CMD_WRITE_TIME, 6'd1, 4'd0, 32'sd0, 32'sh80000000, 1'b0}, 1'b0, '0},
		'{'{CMD_WRITE_TIME, 6'd0, 4'd0, 32'sd0, 32'sh7fffffff, 1'b0}, 1'b0, '0},
		'{'{CMD_EVALUATE, 6'd0, 4'd0, 32'sd0, 32'sd0, 1'b0}, 1'b0, '0}
	};

	// Result checker: every accepted result is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("result with no request behind it");
			end else begin
				exp_res = pending_results.pop_front();
				if (kind !== exp_res.kind)
					report($sformatf("kind %0d, expected %0d", kind, exp_res.kind));
				if (sample_out !== exp_res.sample)
					report($sformatf("sample_out %0d, expected %0d", sample_out,
						exp_res.sample));
				if (error_sum !== exp_res.esum)
					report($sformatf("error_sum %0d, expected %0d", error_sum,
						exp_res.esum));
				if (last_of_run !== exp_res.last)
					report($sformatf("last_of_run %0b, expected %0b", last_of_run,
						exp_res.last));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[waveform_table_interpolator] ERROR");
			$finish;
		end
	end

	// Receiver: a stall rate drawn anew from four levels, including
	// stretches with no stall at all, plus one long hold-off on request
	// so that the block backs up and stalls its request channel.
	initial begin
		int pct, k, hold;
		pct = 0;
		k = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (hold = 0; hold < 600; hold++) @(negedge clk);
				hold_req = 1'b0;
			end
			if (k % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: pct = 0;
					1: pct = 20;
					2: pct = 50;
					default: pct = 85;
				endcase
			end
			k++;
			out_stall <= ($urandom_range(0, 99) < pct);
		end
	end

	// Main sequence.
	initial begin
		request_t r;
		int p, e, ph, j;
		logic [6:0] pts_set [NPHASE];
		logic [6:0] len_set [NPHASE];
		pts_set = '{7'd0, 7'd127, 7'd3, 7'd5};
		len_set = '{7'd31, 7'd0, 7'd5, 7'd9};
		err_acc = '0;
		points_reg = 7'd64;
		length_reg = 5'd16;
		for (p = 0; p < NPTS; p++) begin
			time_copy[p] = '0;
			for (e = 0; e < NELEM; e++) begin
				sample_copy[p*NELEM + e] = '0;
				sample_known[p*NELEM + e] = 1'b0;
			end
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every time is written, and the sample rows that the directed
		// requests read: the first three and the last two.
		for (p = 0; p < NPTS; p++) begin
			r = '{CMD_WRITE_TIME, p[5:0], 4'd0, '0, 32'(p * 65536), 1'b0};
			send_plain(r);
		end
		for (p = 0; p < NPTS; p++)
			if (p < 3 || p >= NPTS - 2)
				for (e = 0; e < NELEM; e++) begin
					r = '{CMD_WRITE_SAMPLE, p[5:0], e[3:0], 32'((p * 16 + e) * 4096), '0,
						1'b0};
					send_plain(r);
				end

		for (j = 0; j < NDIR; j++)
			send_request(DIR_ROWS[j].req, DIR_ROWS[j].typed, DIR_ROWS[j].want);

		// Random phases, each under its own register setting.
		for (ph = 0; ph < NPHASE; ph++) begin
			drain();
			write_reg(CFG_POINTS_IN_USE, pts_set[ph]);
			write_reg(CFG_VECTOR_LENGTH, len_set[ph]);
			load_sorted_times();
			fill_reachable();
			if (ph == 0) hold_req = 1'b1;
			for (j = 0; j < NRAND; j++) send_plain(rand_request());
		end

		drain();
		if (errors == 0) begin
			$display("[waveform_table_interpolator] OK");
		end else begin
			$display("[waveform_table_interpolator] ERROR");
		end
		$finish;
	end

endmodule
